FILE: sv/zrs_pkg.sv
// shared types, constants and state encodings of the zoned request splitter
`default_nettype none
package zrs_pkg;

    localparam int BLK_W = 48;
    localparam int IW = BLK_W + 2;
    localparam int ZW = 33;
    localparam int LW = 17;
    localparam int CW = 33;

    localparam int MAX_COMMANDS_DEF = 64;
    localparam int ADDR_BITS_DEF = 48;

    localparam logic [1:0] OP_READ = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_RD_OOR = 2'd1;
    localparam logic [1:0] ST_WR_OOR = 2'd2;
    localparam logic [1:0] ST_TOO_MANY = 2'd3;

    localparam logic [2:0] REG_ZONE_SIZE = 3'd0;
    localparam logic [2:0] REG_ZONE_CAP = 3'd1;
    localparam logic [2:0] REG_BLOCK_BYTES = 3'd2;
    localparam logic [2:0] REG_MAX_XFER = 3'd3;
    localparam logic [2:0] REG_APPEND_LIM = 3'd4;
    localparam logic [2:0] REG_OWNED_MIN = 3'd5;
    localparam logic [2:0] REG_OWNED_MAX = 3'd6;

    typedef struct packed {
        logic [1:0]  op;
        logic [47:0] start_block;
        logic [31:0] size_bytes;
    } req_t;

    typedef struct packed {
        logic [47:0] cmd_block;
        logic [31:0] buffer_offset_blocks;
        logic [16:0] block_count;
        logic [47:0] next_block;
        logic [1:0]  status;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [ZW-1:0]    zs;
        logic [ZW-1:0]    cap;
        logic [LW-1:0]    bb;
        logic [LW-1:0]    mt;
        logic [LW-1:0]    al;
        logic [BLK_W-1:0] omin;
        logic [BLK_W-1:0] omax;
    } cfg_t;

    typedef struct packed {
        logic          append;
        logic          bad;
        logic [1:0]    status;
        logic [IW-1:0] addr;
        logic [IW-1:0] zstart;
        logic [CW-1:0] blocks;
        logic [LW-1:0] step;
    } job_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_ZONE,
        F_BLK,
        F_GAP,
        F_CHK,
        F_ZN,
        F_LIM,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_COUNT,
        B_EMIT
    } back_state_t;

endpackage
`default_nettype wire

FILE: sv/zrs_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module zrs_div
    import zrs_pkg::*;
#(
    parameter int NUM_W = IW,
    parameter int DEN_W = ZW
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic [NUM_W-1:0]      quo,
    output logic [DEN_W-1:0]      rem
);

    localparam int KW = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic [KW-1:0]     cnt_reg;
    logic              done_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [DEN_W:0]    r_reg;
    logic [DEN_W-1:0]  d_reg;
    logic [DEN_W:0]    trial;
    logic              fit;

    assign trial = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
    assign fit = trial >= {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= KW'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == KW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[NUM_W-2:0], fit};
            r_reg <= fit ? (trial - {1'b0, d_reg}) : trial;
        end
    end

    assign done = done_reg;
    assign quo = q_reg;
    assign rem = r_reg[DEN_W-1:0];

endmodule
`default_nettype wire

FILE: sv/zrs_front.sv
// front end: zone alignment, block rounding and range check
`default_nettype none
module zrs_front
    import zrs_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      job_valid,
    input  wire logic job_ready,
    output job_t      job
);

    localparam logic [47:0] ADDR_MASK =
        (ADDR_BITS >= 48) ? '1 : 48'((64'd1 << ADDR_BITS) - 64'd1);

    front_state_t  state_reg, state_next;
    logic          launch_reg;
    logic          append_reg;
    logic [1:0]    err_reg;
    logic [IW-1:0] addr_reg;
    logic [IW-1:0] zstart_reg;
    logic [31:0]   size_reg;
    logic [CW-1:0] blocks_reg;
    logic [IW-1:0] zones_reg;
    logic          bad_reg;
    logic [LW-1:0] step_reg;

    logic          div_start;
    logic [IW-1:0] div_num;
    logic [ZW-1:0] div_den;
    logic          div_done;
    logic [IW-1:0] div_quo;
    logic [ZW-1:0] div_rem;
    logic [IW-1:0] zend;
    logic [IW-1:0] off;
    logic          chk_bad;

    assign zend = zstart_reg + IW'(cfg.cap);
    assign off = addr_reg - zstart_reg;
    assign chk_bad = (off >= IW'(cfg.cap)) || (addr_reg < IW'(cfg.omin))
        || (zstart_reg > IW'(cfg.omax));

    zrs_div #(.NUM_W(IW), .DEN_W(ZW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        req_ready = 1'b0;
        job_valid = 1'b0;
        div_start = 1'b0;
        div_num = addr_reg;
        div_den = cfg.zs;
        case (state_reg)
            F_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    state_next = F_ZONE;
                end
            end
            F_ZONE:
            begin
                div_start = launch_reg;
                if (div_done)
                begin
                    state_next = F_BLK;
                end
            end
            F_BLK:
            begin
                div_start = launch_reg;
                div_num = IW'(size_reg) + IW'(cfg.bb) - IW'(1);
                div_den = ZW'(cfg.bb);
                if (div_done)
                begin
                    state_next = F_GAP;
                end
            end
            F_GAP:
            begin
                state_next = F_CHK;
            end
            F_CHK:
            begin
                state_next = chk_bad ? F_PUSH : F_ZN;
            end
            F_ZN:
            begin
                div_start = launch_reg;
                div_num = IW'(blocks_reg) + off;
                div_den = cfg.cap;
                if (div_done)
                begin
                    state_next = F_LIM;
                end
            end
            F_LIM:
            begin
                div_start = launch_reg;
                div_num = IW'(cfg.omax) - zstart_reg;
                if (div_done)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                job_valid = 1'b1;
                if (job_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launch_reg <= 1'b0;
        end
        else if (div_start)
        begin
            launch_reg <= 1'b0;
        end
        else if ((state_reg == F_IDLE && req_valid) || div_done ||
                 (state_reg == F_CHK && !chk_bad))
        begin
            launch_reg <= (state_next == F_ZONE) || (state_next == F_BLK) ||
                (state_next == F_ZN) || (state_next == F_LIM);
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (req_valid)
                begin
                    append_reg <= (req.op == OP_APPEND);
                    err_reg <= (req.op == OP_READ) ? ST_RD_OOR : ST_WR_OOR;
                    addr_reg <= {2'b00, req.start_block & ADDR_MASK};
                    size_reg <= req.size_bytes;
                    bad_reg <= 1'b0;
                end
            end
            F_ZONE:
            begin
                if (div_done)
                begin
                    zstart_reg <= addr_reg - IW'(div_rem);
                end
            end
            F_BLK:
            begin
                if (div_done)
                begin
                    blocks_reg <= div_quo[CW-1:0];
                end
            end
            F_GAP:
            begin
                step_reg <= append_reg ? cfg.al : cfg.mt;
                if (addr_reg >= zend)
                begin
                    zstart_reg <= zstart_reg + IW'(cfg.zs);
                    addr_reg <= zstart_reg + IW'(cfg.zs) + (addr_reg - zend);
                end
            end
            F_CHK:
            begin
                bad_reg <= chk_bad;
            end
            F_ZN:
            begin
                if (div_done)
                begin
                    zones_reg <= div_quo;
                end
            end
            F_LIM:
            begin
                if (div_done)
                begin
                    bad_reg <= zones_reg > div_quo;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        job.append = append_reg;
        job.bad = bad_reg;
        job.status = err_reg;
        job.addr = addr_reg;
        job.zstart = zstart_reg;
        job.blocks = blocks_reg;
        job.step = step_reg;
    end

endmodule
`default_nettype wire

FILE: sv/zrs_fifo.sv
// two-word queue between front and back ends
`default_nettype none
module zrs_fifo
    import zrs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    output logic      wr_ready,
    input  wire job_t wr_data,
    output logic      rd_valid,
    input  wire logic rd_ready,
    output job_t      rd_data
);

    job_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

FILE: sv/zrs_back.sv
// back end: command count check, then one command per cycle while the response channel does not stall
`default_nettype none
module zrs_back
    import zrs_pkg::*;
#(
    parameter int MAX_COMMANDS = MAX_COMMANDS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic job_valid,
    output logic      job_ready,
    input  wire job_t job,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    localparam int KW = $clog2(MAX_COMMANDS + 1);

    back_state_t   state_reg, state_next;
    logic [KW-1:0] k_reg;
    logic [CW-1:0] done_reg;
    logic [IW-1:0] addr_reg;
    logic [IW-1:0] zstart_reg;
    logic [IW-1:0] zend_reg;
    logic [IW-1:0] addr0_reg;
    logic [IW-1:0] zstart0_reg;
    logic [IW-1:0] zend0_reg;
    logic          append_reg;
    logic [LW-1:0] step_reg;
    logic [CW-1:0] blocks_reg;
    logic          out_valid_reg;
    rsp_t          out_reg;

    logic          free;
    logic [LW-1:0] cur_a;
    logic [LW-1:0] cur;
    logic [CW-1:0] left;
    logic [IW-1:0] n_addr;
    logic [IW-1:0] s_addr;
    logic [IW-1:0] s_zstart;
    logic [IW-1:0] s_zend;
    logic [CW-1:0] s_done;
    logic          wrap;

    assign free = !out_valid_reg || rsp_ready;
    assign left = blocks_reg - done_reg;
    assign cur_a = ((addr_reg + IW'(step_reg)) >= zend_reg) ?
        LW'(zend_reg - addr_reg) : step_reg;
    assign cur = (left < CW'(cur_a)) ? LW'(left) : cur_a;
    assign n_addr = addr_reg + IW'(cur);
    assign wrap = n_addr >= zend_reg;
    assign s_zstart = wrap ? zstart_reg + IW'(cfg.zs) : zstart_reg;
    assign s_zend = wrap ? zend_reg + IW'(cfg.zs) : zend_reg;
    assign s_addr = wrap ? zstart_reg + IW'(cfg.zs) : n_addr;
    assign s_done = done_reg + CW'(cur);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        job_ready = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                job_ready = free;
                if (job_valid && free && !job.bad && job.blocks != '0)
                begin
                    state_next = B_COUNT;
                end
            end
            B_COUNT:
            begin
                if (done_reg == blocks_reg)
                begin
                    state_next = B_EMIT;
                end
                else if (k_reg == KW'(MAX_COMMANDS) && free)
                begin
                    state_next = B_IDLE;
                end
            end
            B_EMIT:
            begin
                if (free && s_done == blocks_reg)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (job_valid && free && (job.bad || job.blocks == '0))
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                B_COUNT:
                begin
                    if (done_reg != blocks_reg && k_reg == KW'(MAX_COMMANDS) && free)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                B_EMIT:
                begin
                    if (free)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (job_valid && free)
                begin
                    append_reg <= job.append;
                    step_reg <= job.step;
                    blocks_reg <= job.blocks;
                    addr_reg <= job.addr;
                    zstart_reg <= job.zstart;
                    zend_reg <= job.zstart + IW'(cfg.cap);
                    addr0_reg <= job.addr;
                    zstart0_reg <= job.zstart;
                    zend0_reg <= job.zstart + IW'(cfg.cap);
                    done_reg <= '0;
                    k_reg <= '0;
                    out_reg.cmd_block <= '0;
                    out_reg.buffer_offset_blocks <= '0;
                    out_reg.block_count <= '0;
                    out_reg.next_block <= job.addr[BLK_W-1:0];
                    out_reg.status <= job.bad ? job.status : ST_OK;
                    out_reg.last <= 1'b1;
                end
            end
            B_COUNT:
            begin
                if (done_reg == blocks_reg)
                begin
                    addr_reg <= addr0_reg;
                    zstart_reg <= zstart0_reg;
                    zend_reg <= zend0_reg;
                    done_reg <= '0;
                end
                else if (k_reg == KW'(MAX_COMMANDS))
                begin
                    if (free)
                    begin
                        out_reg.cmd_block <= '0;
                        out_reg.buffer_offset_blocks <= '0;
                        out_reg.block_count <= '0;
                        out_reg.next_block <= addr0_reg[BLK_W-1:0];
                        out_reg.status <= ST_TOO_MANY;
                        out_reg.last <= 1'b1;
                    end
                end
                else
                begin
                    addr_reg <= s_addr;
                    zstart_reg <= s_zstart;
                    zend_reg <= s_zend;
                    done_reg <= s_done;
                    k_reg <= k_reg + 1'b1;
                end
            end
            B_EMIT:
            begin
                if (free)
                begin
                    addr_reg <= s_addr;
                    zstart_reg <= s_zstart;
                    zend_reg <= s_zend;
                    done_reg <= s_done;
                    out_reg.cmd_block <= append_reg ? zstart_reg[BLK_W-1:0] :
                        addr_reg[BLK_W-1:0];
                    out_reg.buffer_offset_blocks <= done_reg[31:0];
                    out_reg.block_count <= cur;
                    out_reg.next_block <= s_addr[BLK_W-1:0];
                    out_reg.status <= ST_OK;
                    out_reg.last <= s_done == blocks_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;
    assign rsp = out_reg;

endmodule
`default_nettype wire

FILE: sv/zoned_io_request_splitter_top.sv
// top level of the zoned request splitter: registers, front, queue, back
//
// channel  direction  word
// req      in         op, start_block, size_bytes
// rsp      out        one device command or error per word
// cfg      in         register index and write data
//
// an item takes two passes of the shared bit-serial divider in the front end
// when the early range check fails and four passes otherwise; in the back end
// a good item gets a command count check, then one command word per cycle
// while the response channel does not stall
// reset clears control state and loads the register defaults
// the queue lets the front classify the next word while the back stalls
`default_nettype none
module zoned_io_request_splitter_top
    import zrs_pkg::*;
#(
    parameter int MAX_COMMANDS = MAX_COMMANDS_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire req_t        req,
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output rsp_t             rsp,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);

    logic [ZW-1:0]    zs_reg;
    logic [ZW-1:0]    cap_reg;
    logic [LW-1:0]    bb_reg;
    logic [LW-1:0]    mt_reg;
    logic [LW-1:0]    al_reg;
    logic [BLK_W-1:0] omin_reg;
    logic [BLK_W-1:0] omax_reg;
    cfg_t             cfg;
    logic [ZW-1:0]    cap1;

    job_t f_job;
    logic f_valid;
    logic f_ready;
    job_t b_job;
    logic b_valid;
    logic b_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zs_reg <= ZW'(524288);
            cap_reg <= ZW'(524288);
            bb_reg <= LW'(4096);
            mt_reg <= LW'(32);
            al_reg <= LW'(32);
            omin_reg <= '0;
            omax_reg <= '1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ZONE_SIZE: zs_reg <= {1'b0, cfg_data[31:0]} |
                    {cfg_data[32], 32'd0};
                REG_ZONE_CAP: cap_reg <= cfg_data[ZW-1:0];
                REG_BLOCK_BYTES: bb_reg <= cfg_data[LW-1:0];
                REG_MAX_XFER: mt_reg <= cfg_data[LW-1:0];
                REG_APPEND_LIM: al_reg <= cfg_data[LW-1:0];
                REG_OWNED_MIN: omin_reg <= cfg_data;
                REG_OWNED_MAX: omax_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.zs = (zs_reg == '0) ? ZW'(1) : zs_reg;
        cap1 = (cap_reg == '0) ? ZW'(1) : cap_reg;
        cfg.cap = (cap1 > cfg.zs) ? cfg.zs : cap1;
        cfg.bb = (bb_reg == '0) ? LW'(1) : bb_reg;
        cfg.mt = (mt_reg == '0) ? LW'(1) : mt_reg;
        cfg.al = (al_reg == '0) ? LW'(1) : al_reg;
        cfg.omin = omin_reg;
        cfg.omax = omax_reg;
    end

    zrs_front #(.ADDR_BITS(ADDR_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    zrs_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_job),
        .rd_valid (b_valid),
        .rd_ready (b_ready),
        .rd_data  (b_job)
    );

    zrs_back #(.MAX_COMMANDS(MAX_COMMANDS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (b_valid),
        .job_ready (b_ready),
        .job       (b_job),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire
